// ===== src/imurlp_pkg.sv =====
// Shared types and constants for the IMU axis remap and accel low-pass block.
// Holds beat structs, coefficient and control structs, register indexes and reset values.
// No dependencies.
package imurlp_pkg;

    // Field widths fixed by the sensor format
    localparam int SAMPLE_BITS   = 16;
    localparam int HIST_BITS     = 32;
    localparam int COEF_BITS     = 32;
    localparam int MAP_BITS      = 6;
    localparam int NEG_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [HIST_BITS-1:0]   t_hist;
    typedef logic signed [COEF_BITS-1:0]   t_coef;

    // Input beat: raw sensor axes
    typedef struct packed {
        t_sample raw_gyro_x;
        t_sample raw_gyro_y;
        t_sample raw_gyro_z;
        t_sample raw_accel_x;
        t_sample raw_accel_y;
        t_sample raw_accel_z;
    } t_in_beat;

    // Output beat: body-frame gyro and filtered accel
    typedef struct packed {
        t_sample body_gyro_x;
        t_sample body_gyro_y;
        t_sample body_gyro_z;
        t_sample smooth_accel_x;
        t_sample smooth_accel_y;
        t_sample smooth_accel_z;
    } t_out_beat;

    // Low-pass coefficients, signed Q2.30 by default
    typedef struct packed {
        t_coef feedback_coef_one;
        t_coef feedback_coef_two;
        t_coef input_coef;
    } t_iir_coef;

    // History update control from the top level to each axis filter
    typedef struct packed {
        logic advance;
        logic primed;
    } t_hist_ctl;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AXIS_MAP = 3'd0,
        CFG_NEG_MASK = 3'd1,
        CFG_GOFF_X   = 3'd2,
        CFG_GOFF_Y   = 3'd3,
        CFG_GOFF_Z   = 3'd4,
        CFG_COEF_A1  = 3'd5,
        CFG_COEF_A2  = 3'd6,
        CFG_COEF_B0  = 3'd7
    } t_cfg_idx;

    // Source axis select codes
    localparam logic [1:0] SRC_AXIS_X = 2'd0;
    localparam logic [1:0] SRC_AXIS_Y = 2'd1;
    localparam logic [1:0] SRC_AXIS_Z = 2'd2;
    localparam logic [1:0] SRC_NONE   = 2'd3;

    // Register reset values
    localparam logic [MAP_BITS-1:0] AXIS_MAP_RST = 6'd33;
    localparam logic [NEG_BITS-1:0] NEG_MASK_RST = 3'd2;
    localparam t_coef COEF_A1_RST = 32'sd2071735499;
    localparam t_coef COEF_A2_RST = -32'sd1000494912;
    localparam t_coef COEF_B0_RST = 32'sd2501237;

endpackage

// ===== src/imu_axis_remap_and_accel_lowpass_top.sv =====
// Top level: IMU axis remap with gyro offset and per-axis accel low-pass.
// Input register, remap and three filter axes, result register; config registers.
// Depends on imurlp_pkg, imurlp_remap, imurlp_iir_axis.
//
//  Channel | Valid       | Stall       | Data         | Direction
//  --------+-------------+-------------+--------------+----------
//  in      | i_in_valid  | o_in_stall  | i_in_data    | sink
//  out     | o_out_valid | i_out_stall | o_out_data   | source
//  cfg     | i_cfg_we    | -           | i_cfg_data   | sink (index i_cfg_idx)
//
// One beat per cycle sustained while the output is not stalled; an accepted beat passes
// through the input register, then the result register, before it reaches the output.
// The filter recursion closes through each axis's three multipliers and its history
// registers.
// Reset restores register defaults and empties both stages; the first beat after
// reset preloads the filter history. A stalled output holds its beat, and the input
// register keeps taking a beat as long as the result register can move.
module imu_axis_remap_and_accel_lowpass_top import imurlp_pkg::*; #(
    parameter int COEF_FRAC_BITS    = 30,
    parameter int HISTORY_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_beat                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_beat                o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration registers
    logic [MAP_BITS-1:0] r_axis_map;
    logic [NEG_BITS-1:0] r_neg_mask;
    t_sample             r_goff [3];
    t_iir_coef           r_coef;

    // pipeline registers
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      r_primed;

    logic      n_in_valid;
    logic      n_out_valid;
    logic      in_accept;
    logic      advance;
    t_hist_ctl hist_ctl;
    t_out_beat n_out;

    t_sample   raw_gyro  [3];
    t_sample   raw_accel [3];
    t_sample   body_gyro [3];
    t_hist     xq        [3];
    t_sample   smooth    [3];

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_comb begin
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_primed <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_map               <= AXIS_MAP_RST;
            r_neg_mask               <= NEG_MASK_RST;
            r_goff[0]                <= '0;
            r_goff[1]                <= '0;
            r_goff[2]                <= '0;
            r_coef.feedback_coef_one <= COEF_A1_RST;
            r_coef.feedback_coef_two <= COEF_A2_RST;
            r_coef.input_coef        <= COEF_B0_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AXIS_MAP: r_axis_map               <= i_cfg_data[MAP_BITS-1:0];
                CFG_NEG_MASK: r_neg_mask               <= i_cfg_data[NEG_BITS-1:0];
                CFG_GOFF_X:   r_goff[0]                <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_GOFF_Y:   r_goff[1]                <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_GOFF_Z:   r_goff[2]                <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_COEF_A1:  r_coef.feedback_coef_one <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_A2:  r_coef.feedback_coef_two <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_B0:  r_coef.input_coef        <= i_cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // remap
    assign raw_gyro[0]  = r_in.raw_gyro_x;
    assign raw_gyro[1]  = r_in.raw_gyro_y;
    assign raw_gyro[2]  = r_in.raw_gyro_z;
    assign raw_accel[0] = r_in.raw_accel_x;
    assign raw_accel[1] = r_in.raw_accel_y;
    assign raw_accel[2] = r_in.raw_accel_z;

    imurlp_remap #(
        .HISTORY_FRAC_BITS(HISTORY_FRAC_BITS)
    ) u_remap (
        .i_map   (r_axis_map),
        .i_neg   (r_neg_mask),
        .i_goff  (r_goff),
        .i_gyro  (raw_gyro),
        .i_accel (raw_accel),
        .o_gyro  (body_gyro),
        .o_xq    (xq)
    );

    // per-axis low-pass
    assign hist_ctl.advance = advance;
    assign hist_ctl.primed  = r_primed;

    for (genvar k = 0; k < 3; k++) begin : g_lpf
        imurlp_iir_axis #(
            .COEF_FRAC_BITS    (COEF_FRAC_BITS),
            .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
        ) u_iir (
            .i_clk    (i_clk),
            .i_ctl    (hist_ctl),
            .i_coef   (r_coef),
            .i_xq     (xq[k]),
            .o_sample (smooth[k])
        );
    end

    // result beat
    assign n_out.body_gyro_x    = body_gyro[0];
    assign n_out.body_gyro_y    = body_gyro[1];
    assign n_out.body_gyro_z    = body_gyro[2];
    assign n_out.smooth_accel_x = smooth[0];
    assign n_out.smooth_accel_y = smooth[1];
    assign n_out.smooth_accel_z = smooth[2];

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // history is primed once any beat has gone through the filter
    a_primed_after_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_primed)
        else $error("filter history not primed after a beat");

    // a new result only comes from a beat held in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result beat without an input beat");

    // an empty input register never stalls the input side
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled while input register empty");

    // a held result keeps the input beat waiting in place
    a_hold_in_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=> (r_in_valid && $stable(r_in)))
        else $error("input beat lost while result stalled");
`endif

endmodule

// ===== src/imurlp_remap.sv =====
// Axis remap: signed axis permutation, gyro offset and saturation, accel scaling
// to the filter history format. Pure combinational logic.
// Depends on imurlp_pkg.
module imurlp_remap import imurlp_pkg::*; #(
    parameter int HISTORY_FRAC_BITS = 16
) (
    input  logic [MAP_BITS-1:0] i_map,
    input  logic [NEG_BITS-1:0] i_neg,
    input  t_sample             i_goff  [3],
    input  t_sample             i_gyro  [3],
    input  t_sample             i_accel [3],
    output t_sample             o_gyro  [3],
    output t_hist               o_xq    [3]
);

    localparam int SB  = SAMPLE_BITS;
    localparam int SHW = SAMPLE_BITS + HISTORY_FRAC_BITS;
    // scaled accel width, at least one bit over history so saturation is visible
    localparam int XW  = (SHW > HIST_BITS) ? SHW : HIST_BITS + 1;

    localparam logic signed [SB+1:0] G_MAX = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [SB+1:0] G_MIN = {3'b111, {(SB-1){1'b0}}};
    localparam logic signed [SB:0]   A_MAX = {2'b00, {(SB-1){1'b1}}};
    localparam logic signed [SB:0]   A_MIN = {2'b11, {(SB-1){1'b0}}};
    localparam logic signed [XW-1:0] X_MAX = {{(XW-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] X_MIN = {{(XW-HIST_BITS+1){1'b1}}, {(HIST_BITS-1){1'b0}}};

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [1:0]             code;
        logic signed [SB:0]     g_pick;
        logic signed [SB:0]     a_pick;
        logic signed [SB:0]     g_sgn;
        logic signed [SB:0]     a_sgn;
        logic signed [SB+1:0]   g_sum;
        t_sample                a_sat;
        logic signed [XW-1:0]   a_wide;

        assign code = i_map[2*k +: 2];

        // source axis select
        always_comb begin
            case (code)
                SRC_AXIS_X: begin
                    g_pick = (SB+1)'(i_gyro[0]);
                    a_pick = (SB+1)'(i_accel[0]);
                end
                SRC_AXIS_Y: begin
                    g_pick = (SB+1)'(i_gyro[1]);
                    a_pick = (SB+1)'(i_accel[1]);
                end
                SRC_AXIS_Z: begin
                    g_pick = (SB+1)'(i_gyro[2]);
                    a_pick = (SB+1)'(i_accel[2]);
                end
                default: begin
                    g_pick = '0;
                    a_pick = '0;
                end
            endcase
        end

        // negate; one extra bit holds the negated most negative value
        assign g_sgn = i_neg[k] ? -g_pick : g_pick;
        assign a_sgn = i_neg[k] ? -a_pick : a_pick;

        // gyro offset, then clamp to sample range
        assign g_sum = (SB+2)'(g_sgn) + (SB+2)'(i_goff[k]);
        always_comb begin
            if (g_sum > G_MAX) begin
                o_gyro[k] = G_MAX[SB-1:0];
            end else if (g_sum < G_MIN) begin
                o_gyro[k] = G_MIN[SB-1:0];
            end else begin
                o_gyro[k] = g_sum[SB-1:0];
            end
        end

        // accel clamp, scale to history format, clamp to history range
        always_comb begin
            if (a_sgn > A_MAX) begin
                a_sat = A_MAX[SB-1:0];
            end else if (a_sgn < A_MIN) begin
                a_sat = A_MIN[SB-1:0];
            end else begin
                a_sat = a_sgn[SB-1:0];
            end
        end

        assign a_wide = XW'(a_sat) <<< HISTORY_FRAC_BITS;

        always_comb begin
            if (a_wide > X_MAX) begin
                o_xq[k] = X_MAX[HIST_BITS-1:0];
            end else if (a_wide < X_MIN) begin
                o_xq[k] = X_MIN[HIST_BITS-1:0];
            end else begin
                o_xq[k] = a_wide[HIST_BITS-1:0];
            end
        end
    end

endmodule

// ===== src/imurlp_iir_axis.sv =====
// One axis of the second-order recursive low-pass: y = a1*y1 + a2*y2 + b0*x.
// Holds the two history registers and closes the recursion through them.
// Depends on imurlp_pkg.
module imurlp_iir_axis import imurlp_pkg::*; #(
    parameter int COEF_FRAC_BITS    = 30,
    parameter int HISTORY_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  t_hist_ctl i_ctl,
    input  t_iir_coef i_coef,
    input  t_hist     i_xq,
    output t_sample   o_sample
);

    localparam int PW   = COEF_BITS + HIST_BITS;
    localparam int SUMW = PW + 2;
    localparam int OW   = HIST_BITS + 1;

    localparam logic signed [SUMW-1:0] SUM_RND = {{(SUMW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);
    localparam logic signed [SUMW-1:0] H_MAX   =
        {{(SUMW-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [SUMW-1:0] H_MIN   =
        {{(SUMW-HIST_BITS+1){1'b1}}, {(HIST_BITS-1){1'b0}}};
    localparam logic signed [OW-1:0]   OUT_RND = {{(OW-1){1'b0}}, 1'b1} << (HISTORY_FRAC_BITS-1);
    localparam logic signed [OW-1:0]   S_MAX   =
        {{(OW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [OW-1:0]   S_MIN   =
        {{(OW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    t_hist                 r_newer;
    t_hist                 r_older;
    t_hist                 newer_use;
    t_hist                 older_use;
    logic signed [PW-1:0]  prod_a1;
    logic signed [PW-1:0]  prod_a2;
    logic signed [PW-1:0]  prod_b0;
    logic signed [SUMW-1:0] acc;
    logic signed [SUMW-1:0] acc_sh;
    t_hist                 n_newer;
    logic signed [OW-1:0]  out_rnd;
    logic signed [OW-1:0]  out_sh;

    // first beat preloads both taps with its own input
    assign newer_use = i_ctl.primed ? r_newer : i_xq;
    assign older_use = i_ctl.primed ? r_older : i_xq;

    // three 32x32 products, summed exactly
    assign prod_a1 = PW'(i_coef.feedback_coef_one) * PW'(newer_use);
    assign prod_a2 = PW'(i_coef.feedback_coef_two) * PW'(older_use);
    assign prod_b0 = PW'(i_coef.input_coef) * PW'(i_xq);

    assign acc    = SUMW'(prod_a1) + SUMW'(prod_a2) + SUMW'(prod_b0) + SUM_RND;
    assign acc_sh = acc >>> COEF_FRAC_BITS;

    // clamp to history range
    always_comb begin
        if (acc_sh > H_MAX) begin
            n_newer = H_MAX[HIST_BITS-1:0];
        end else if (acc_sh < H_MIN) begin
            n_newer = H_MIN[HIST_BITS-1:0];
        end else begin
            n_newer = acc_sh[HIST_BITS-1:0];
        end
    end

    // round half up to integer, clamp to sample range
    assign out_rnd = OW'(n_newer) + OUT_RND;
    assign out_sh  = out_rnd >>> HISTORY_FRAC_BITS;

    always_comb begin
        if (out_sh > S_MAX) begin
            o_sample = S_MAX[SAMPLE_BITS-1:0];
        end else if (out_sh < S_MIN) begin
            o_sample = S_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_sample = out_sh[SAMPLE_BITS-1:0];
        end
    end

    // history shift when the beat moves to the result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_older <= newer_use;
            r_newer <= n_newer;
        end
    end

endmodule
